[rtl/core/sde_pkg.sv]
// ----------------------------------------------------------------------------
// sde_pkg
// Shared widths, register indexes, tap tables and types of the side distance
// edge detector.
// ----------------------------------------------------------------------------
package sde_pkg;

    localparam int SAMPLE_W = 16;
    localparam int HIST_W   = 8;
    localparam int THR_W    = 15;
    localparam int RESP_W   = 16;
    localparam int SUM_W    = 17;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 8'd1;

    localparam logic [HIST_W-1:0] CLAMP_LIMIT_RESET    = 8'd200;
    localparam logic [THR_W-1:0]  EDGE_THRESHOLD_RESET = 15'd2000;
    localparam logic [HIST_W-1:0] HISTORY_RESET        = 8'd60;

    localparam int GAUSS_TAPS  [5] = '{2, 4, 5, 4, 2};
    localparam int SMOOTH_TAPS [5] = '{0, 1, 2, 1, 0};

    typedef enum logic [1:0] {
        EDGE_NONE  = 2'd0,
        EDGE_START = 2'd1,
        EDGE_END   = 2'd2
    } t_edge_kind;

    // filtered values needed by the edge decision
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    dip;
        logic                    peak;
    } t_filt;

endpackage

[rtl/core/sde_history.sv]
// ----------------------------------------------------------------------------
// sde_history
// Per-side clamped sample histories, shared warm-up counter and the
// snapshot register that feeds the filter stage.
// ----------------------------------------------------------------------------
module sde_history #(
    parameter int HISTORY_LENGTH = 6
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_accept,
    input  logic [sde_pkg::SAMPLE_W-1:0]                i_sample,
    input  logic                                        i_side,
    input  logic [sde_pkg::HIST_W-1:0]                  i_clamp_limit,
    output logic [HISTORY_LENGTH-1:0][sde_pkg::HIST_W-1:0] o_hist,
    output logic                                        o_side,
    output logic                                        o_warm
);

    localparam int CNT_W = $clog2(HISTORY_LENGTH + 3);
    localparam logic [CNT_W-1:0] WARM_TARGET = CNT_W'(HISTORY_LENGTH + 2);

    logic [HISTORY_LENGTH-1:0][sde_pkg::HIST_W-1:0] r_left, n_left;
    logic [HISTORY_LENGTH-1:0][sde_pkg::HIST_W-1:0] r_right, n_right;
    logic [HISTORY_LENGTH-1:0][sde_pkg::HIST_W-1:0] r_snap, n_snap;
    logic [CNT_W-1:0]                               r_cnt, n_cnt;
    logic                                           r_side, r_warm;
    logic [sde_pkg::HIST_W-1:0]                     clamped;
    logic                                           active;

    always_comb begin
        if (i_sample > {{(sde_pkg::SAMPLE_W - sde_pkg::HIST_W){1'b0}}, i_clamp_limit}) begin
            clamped = i_clamp_limit;
        end else begin
            clamped = i_sample[sde_pkg::HIST_W-1:0];
        end
    end

    assign active = (r_cnt >= WARM_TARGET);

    always_comb begin
        n_left  = r_left;
        n_right = r_right;
        n_cnt   = r_cnt;
        // newest value at entry 0
        if (i_side) begin
            n_snap = {r_left[HISTORY_LENGTH-2:0], clamped};
        end else begin
            n_snap = {r_right[HISTORY_LENGTH-2:0], clamped};
        end
        if (i_accept) begin
            if (i_side) begin
                n_left = n_snap;
            end else begin
                n_right = n_snap;
            end
            if (!active) begin
                n_cnt = r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= {HISTORY_LENGTH{sde_pkg::HISTORY_RESET}};
            r_right <= {HISTORY_LENGTH{sde_pkg::HISTORY_RESET}};
            r_cnt   <= '0;
        end else begin
            r_left  <= n_left;
            r_right <= n_right;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_snap <= n_snap;
            r_side <= i_side;
            r_warm <= active;
        end
    end

    assign o_hist = r_snap;
    assign o_side = r_side;
    assign o_warm = r_warm;

endmodule

[rtl/core/sde_filter.sv]
// ----------------------------------------------------------------------------
// sde_filter
// Gaussian, smoothing and central difference passes over one history
// snapshot, with end values replicated, and the slope tests at the center.
// ----------------------------------------------------------------------------
module sde_filter #(
    parameter int HISTORY_LENGTH = 6
) (
    input  logic [HISTORY_LENGTH-1:0][sde_pkg::HIST_W-1:0] i_hist,
    output sde_pkg::t_filt                                 o_filt
);

    localparam int GW = 13;
    localparam int SW = 15;
    localparam int DW = 16;

    logic [GW-1:0]        gauss  [HISTORY_LENGTH];
    logic [SW-1:0]        smooth [HISTORY_LENGTH];
    logic signed [DW-1:0] diff   [HISTORY_LENGTH];

    function automatic int edge_idx(input int k);
        if (k < 0) begin
            return 0;
        end
        if (k > HISTORY_LENGTH - 1) begin
            return HISTORY_LENGTH - 1;
        end
        return k;
    endfunction

    always_comb begin
        logic [GW-1:0] acc;
        for (int i = 0; i < HISTORY_LENGTH; i++) begin
            acc = '0;
            for (int t = 0; t < 5; t++) begin
                acc = acc + GW'(i_hist[edge_idx(i + t - 2)]) * GW'(sde_pkg::GAUSS_TAPS[t]);
            end
            gauss[i] = acc;
        end
    end

    always_comb begin
        logic [SW-1:0] acc;
        for (int i = 0; i < HISTORY_LENGTH; i++) begin
            acc = '0;
            for (int t = 0; t < 5; t++) begin
                acc = acc + SW'(gauss[edge_idx(i + t - 2)]) * SW'(sde_pkg::SMOOTH_TAPS[t]);
            end
            smooth[i] = acc;
        end
    end

    // central difference: next minus previous
    always_comb begin
        for (int i = 0; i < HISTORY_LENGTH; i++) begin
            diff[i] = $signed({1'b0, smooth[edge_idx(i + 1)]})
                    - $signed({1'b0, smooth[edge_idx(i - 1)]});
        end
    end

    always_comb begin
        o_filt.sum  = sde_pkg::SUM_W'(diff[3]) + sde_pkg::SUM_W'(diff[4]);
        o_filt.dip  = (diff[2] > diff[3]) && (diff[5] > diff[4]);
        o_filt.peak = (diff[2] < diff[3]) && (diff[5] < diff[4]);
    end

endmodule

[rtl/core/side_distance_edge_detector.sv]
// ----------------------------------------------------------------------------
// side_distance_edge_detector
// Clamps side-tagged distance samples into per-side histories, filters them
// and flags minimum or maximum edges against a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one sample and its side.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   request: edge kind, side echo, warm-up flag and the saturated response.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; index 0 is
//   the clamp limit, index 1 the edge threshold, other indexes are dropped.
//   At accept the history is updated and snapshotted, and the filter cascade
//   runs from that snapshot into the result register.
//   Throughput is one request per cycle while the receiver is ready, set
//   by the single filter stage between snapshot and result registers.
//   Reset fills both histories with 60, clears the warm-up count and loads
//   the register defaults. When the receiver stalls, the result register and
//   snapshot hold; o_in_ready drops only once both stages are full.
// ----------------------------------------------------------------------------
module side_distance_edge_detector #(
    parameter int HISTORY_LENGTH = 6
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [sde_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic                            i_side,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_edge_kind,
    output logic                            o_side_echo,
    output logic                            o_warmed_up,
    output logic signed [sde_pkg::RESP_W-1:0] o_response,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sde_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sde_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [sde_pkg::HIST_W-1:0] r_clamp_limit;
    logic [sde_pkg::THR_W-1:0]  r_edge_threshold;

    logic r_snap_valid, n_snap_valid;
    logic r_out_valid, n_out_valid;
    logic out_load, snap_move, in_accept;

    logic [HISTORY_LENGTH-1:0][sde_pkg::HIST_W-1:0] snap_hist;
    logic                                           snap_side;
    logic                                           snap_warm;
    sde_pkg::t_filt                                 filt;

    sde_pkg::t_edge_kind             n_kind, r_kind;
    logic signed [sde_pkg::RESP_W-1:0] n_resp, r_resp;
    logic                            r_side, r_warm;
    logic signed [sde_pkg::SUM_W-1:0] neg_thr, pos_thr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp_limit    <= sde_pkg::CLAMP_LIMIT_RESET;
            r_edge_threshold <= sde_pkg::EDGE_THRESHOLD_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sde_pkg::CFG_CLAMP_LIMIT: begin
                    r_clamp_limit <= i_cfg_data[sde_pkg::HIST_W-1:0];
                end
                sde_pkg::CFG_EDGE_THRESHOLD: begin
                    r_edge_threshold <= i_cfg_data[sde_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control
    assign out_load   = !r_out_valid || i_out_ready;
    assign snap_move  = r_snap_valid && out_load;
    assign o_in_ready = !r_snap_valid || out_load;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_snap_valid = r_snap_valid;
        n_out_valid  = r_out_valid;
        if (in_accept) begin
            n_snap_valid = 1'b1;
        end else if (snap_move) begin
            n_snap_valid = 1'b0;
        end
        if (snap_move) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_snap_valid <= n_snap_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    sde_history #(
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_history (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_sample      (i_sample),
        .i_side        (i_side),
        .i_clamp_limit (r_clamp_limit),
        .o_hist        (snap_hist),
        .o_side        (snap_side),
        .o_warm        (snap_warm)
    );

    sde_filter #(
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_filter (
        .i_hist (snap_hist),
        .o_filt (filt)
    );

    assign pos_thr = $signed({2'b00, r_edge_threshold});
    assign neg_thr = -pos_thr;

    always_comb begin
        n_kind = sde_pkg::EDGE_NONE;
        if (snap_warm) begin
            if ((filt.sum < neg_thr) && filt.dip) begin
                n_kind = sde_pkg::EDGE_START;
            end
            if ((filt.sum > pos_thr) && filt.peak) begin
                n_kind = sde_pkg::EDGE_END;
            end
        end
    end

    // saturate the 17-bit sum to the reported width
    always_comb begin
        if (filt.sum[sde_pkg::SUM_W-1] != filt.sum[sde_pkg::SUM_W-2]) begin
            n_resp = filt.sum[sde_pkg::SUM_W-1] ? 16'sh8000 : 16'sh7fff;
        end else begin
            n_resp = filt.sum[sde_pkg::RESP_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap_move) begin
            r_kind <= n_kind;
            r_resp <= n_resp;
            r_side <= snap_side;
            r_warm <= snap_warm;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_edge_kind = r_kind;
    assign o_side_echo = r_side;
    assign o_warmed_up = r_warm;
    assign o_response  = r_resp;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the side distance edge detector: drives side-tagged
// samples and register writes through the valid/ready channels, predicts
// every result from its own copy of the histories and registers, and checks
// the results in order under several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HIST_LEN         = 6;
    localparam int WARMUP_TARGET    = HIST_LEN + 2;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int HOLD_CYCLES      = 300;
    localparam int ROUNDS           = 8;
    localparam int ITEMS_PER_ROUND  = 232;
    localparam int DIFF_TAPS [5]    = '{0, -1, 0, 1, 0};
    localparam logic SIDE_RIGHT     = 1'b0;
    localparam logic SIDE_LEFT      = 1'b1;
    localparam int RESP_MAX         = 32767;
    localparam int RESP_MIN         = -32768;

    class edge_tracker;
        typedef struct {
            sde_pkg::t_edge_kind                kind;
            logic                               side;
            logic                               warm;
            logic signed [sde_pkg::RESP_W-1:0]  resp;
        } t_outcome;

        logic [sde_pkg::HIST_W-1:0] hist [2][HIST_LEN];
        int                         warm_seen;
        logic [sde_pkg::HIST_W-1:0] clamp;
        logic [sde_pkg::THR_W-1:0]  thr;
        t_outcome                   awaited [$];
        int                         mismatches;

        function new();
            foreach (hist[s, i]) hist[s][i] = sde_pkg::HISTORY_RESET;
            warm_seen  = 0;
            clamp      = sde_pkg::CLAMP_LIMIT_RESET;
            thr        = sde_pkg::EDGE_THRESHOLD_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(logic [sde_pkg::CFG_IDX_W-1:0]  idx,
                              logic [sde_pkg::CFG_DATA_W-1:0] data);
            if (idx == sde_pkg::CFG_CLAMP_LIMIT) begin
                clamp = data[sde_pkg::HIST_W-1:0];
            end else if (idx == sde_pkg::CFG_EDGE_THRESHOLD) begin
                thr = data[sde_pkg::THR_W-1:0];
            end
        endfunction

        // 5-tap filter, taps beyond either end repeat the end value
        function void filter5(input int src [HIST_LEN], input int taps [5],
                              output int dst [HIST_LEN]);
            int acc;
            int k;
            for (int i = 0; i < HIST_LEN; i++) begin
                acc = 0;
                for (int t = 0; t < 5; t++) begin
                    k = i + t - 2;
                    if (k < 0) k = 0;
                    if (k > HIST_LEN - 1) k = HIST_LEN - 1;
                    acc += src[k] * taps[t];
                end
                dst[i] = acc;
            end
        endfunction

        function void take_sample(logic [sde_pkg::SAMPLE_W-1:0] s, logic sd);
            int       a [HIST_LEN];
            int       b [HIST_LEN];
            int       c [HIST_LEN];
            int       f [HIST_LEN];
            int       tot;
            int       lim;
            bit       active;
            t_outcome o;
            for (int i = HIST_LEN - 1; i > 0; i--) hist[sd][i] = hist[sd][i-1];
            hist[sd][0] = (s > clamp) ? clamp : s[sde_pkg::HIST_W-1:0];
            active = (warm_seen >= WARMUP_TARGET);
            if (!active) warm_seen++;
            for (int i = 0; i < HIST_LEN; i++) a[i] = int'(hist[sd][i]);
            filter5(a, sde_pkg::GAUSS_TAPS, b);
            filter5(b, sde_pkg::SMOOTH_TAPS, c);
            filter5(c, DIFF_TAPS, f);
            tot    = f[3] + f[4];
            lim    = int'(thr);
            o.kind = sde_pkg::EDGE_NONE;
            if (active) begin
                if (tot < -lim && f[2] > f[3] && f[5] > f[4]) o.kind = sde_pkg::EDGE_START;
                if (tot > lim && f[2] < f[3] && f[5] < f[4]) o.kind = sde_pkg::EDGE_END;
            end
            if (tot > RESP_MAX) tot = RESP_MAX;
            if (tot < RESP_MIN) tot = RESP_MIN;
            o.side = sd;
            o.warm = active;
            o.resp = tot[sde_pkg::RESP_W-1:0];
            awaited.push_back(o);
        endfunction

        function void match_result(logic [1:0] kind, logic sd, logic warm,
                                   logic signed [sde_pkg::RESP_W-1:0] resp);
            t_outcome o;
            if (awaited.size() == 0) begin
                $display("%0t unexpected result: kind %0d side %0d warm %0d response %0d",
                         $time, kind, sd, warm, resp);
                mismatches++;
                return;
            end
            o = awaited.pop_front();
            if (kind !== o.kind) begin
                $display("%0t edge_kind expected %0d actual %0d", $time, o.kind, kind);
                mismatches++;
            end
            if (sd !== o.side) begin
                $display("%0t side_echo expected %0d actual %0d", $time, o.side, sd);
                mismatches++;
            end
            if (warm !== o.warm) begin
                $display("%0t warmed_up expected %0d actual %0d", $time, o.warm, warm);
                mismatches++;
            end
            if (resp !== o.resp) begin
                $display("%0t response expected %0d actual %0d", $time, o.resp, resp);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction
    endclass

    logic                              i_clk       = 1'b0;
    logic                              i_rst_n     = 1'b0;
    logic                              i_in_valid  = 1'b0;
    logic                              o_in_ready;
    logic [sde_pkg::SAMPLE_W-1:0]      i_sample    = '0;
    logic                              i_side      = 1'b0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [1:0]                        o_edge_kind;
    logic                              o_side_echo;
    logic                              o_warmed_up;
    logic signed [sde_pkg::RESP_W-1:0] o_response;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [sde_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [sde_pkg::CFG_DATA_W-1:0]    i_cfg_data  = '0;

    edge_tracker tracker;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          want_hold     = 1'b0;
    int          hold_left     = 0;
    int          cycles        = 0;

    side_distance_edge_detector #(
        .HISTORY_LENGTH (HIST_LEN)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .i_side      (i_side),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_edge_kind (o_edge_kind),
        .o_side_echo (o_side_echo),
        .o_warmed_up (o_warmed_up),
        .o_response  (o_response),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when asked for one
    always @(posedge i_clk) begin
        if (want_hold) begin
            want_hold = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) tracker.take_sample(i_sample, i_side);
            if (o_out_valid && i_out_ready) begin
                tracker.match_result(o_edge_kind, o_side_echo, o_warmed_up, o_response);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic write_reg(logic [sde_pkg::CFG_IDX_W-1:0]  idx,
                             logic [sde_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.set_reg(idx, data);
    endtask

    // caller stands at a rising edge; returns at the edge that takes the request
    task automatic send_item(logic [sde_pkg::SAMPLE_W-1:0] s, logic sd);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_sample   <= s;
        i_side     <= sd;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        // let the monitor record the last accepted request first
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // a run of one level on one side, with jitter, outliers and stray requests
    task automatic drive_level(logic sd, int level, int n, inout int sent);
        int roll;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_item(sde_pkg::SAMPLE_W'($urandom_range(16'hFFFF)), sd);
            end else if (roll < 22) begin
                send_item(sde_pkg::SAMPLE_W'($urandom_range(16'hFFFF)), ~sd);
            end else begin
                send_item(sde_pkg::SAMPLE_W'(level + $urandom_range(4)), sd);
            end
            sent++;
        end
    endtask

    task automatic run_random(int budget, bit with_hold);
        int   sent;
        int   lo;
        int   hi;
        logic sd;
        sent = 0;
        while (sent < budget) begin
            if (with_hold && sent >= 40) begin
                want_hold = 1'b1;
                with_hold = 1'b0;
            end
            if ($urandom_range(99) < 75) begin
                sd = $urandom_range(1);
                lo = $urandom_range(255);
                hi = $urandom_range(255);
                drive_level(sd, lo, $urandom_range(9, 3), sent);
                drive_level(sd, hi, $urandom_range(9, 3), sent);
                // pulse shape: return to the first level
                if ($urandom_range(1)) drive_level(sd, lo, $urandom_range(9, 3), sent);
            end else begin
                repeat ($urandom_range(4, 1)) begin
                    send_item(sde_pkg::SAMPLE_W'($urandom_range(16'hFFFF)),
                              $urandom_range(1));
                    sent++;
                end
            end
        end
    endtask

    task automatic configure(int round);
        case (round)
            0: begin
                write_reg(sde_pkg::CFG_CLAMP_LIMIT, 16'd255);
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD, 16'd0);
            end
            1: begin
                write_reg(sde_pkg::CFG_CLAMP_LIMIT, 16'd0);
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD, 16'd32767);
            end
            2: begin
                write_reg(sde_pkg::CFG_CLAMP_LIMIT, 16'd1);
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD, 16'd0);
            end
            3: begin
                write_reg(sde_pkg::CFG_CLAMP_LIMIT,
                          sde_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD,
                          sde_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
            end
            4: begin
                // indexes past the two registers must be dropped
                write_reg(sde_pkg::CFG_IDX_W'($urandom_range(2**sde_pkg::CFG_IDX_W - 1,
                                              sde_pkg::CFG_EDGE_THRESHOLD + 1)),
                          sde_pkg::CFG_DATA_W'($urandom_range(16'hFFFF)));
                write_reg(sde_pkg::CFG_CLAMP_LIMIT,
                          sde_pkg::CFG_DATA_W'(sde_pkg::CLAMP_LIMIT_RESET));
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD,
                          sde_pkg::CFG_DATA_W'(sde_pkg::EDGE_THRESHOLD_RESET));
            end
            5: begin
                write_reg(sde_pkg::CFG_CLAMP_LIMIT, 16'd255);
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD, 16'd32767);
            end
            default: begin
                write_reg(sde_pkg::CFG_CLAMP_LIMIT,
                          sde_pkg::CFG_DATA_W'($urandom_range(255, 1)));
                write_reg(sde_pkg::CFG_EDGE_THRESHOLD,
                          sde_pkg::CFG_DATA_W'($urandom_range(4000)));
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        tracker = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: clamp edges, extremes of the sample, warm-up, steps
        send_item(16'd0, SIDE_RIGHT);
        send_item(16'hFFFF, SIDE_RIGHT);
        send_item(sde_pkg::SAMPLE_W'(sde_pkg::CLAMP_LIMIT_RESET), SIDE_RIGHT);
        send_item(sde_pkg::SAMPLE_W'(sde_pkg::CLAMP_LIMIT_RESET) + 16'd1, SIDE_RIGHT);
        send_item(16'd255, SIDE_LEFT);
        send_item(16'd0, SIDE_LEFT);
        send_item(16'd1, SIDE_LEFT);
        send_item(16'd199, SIDE_LEFT);
        repeat (4) send_item(16'd0, SIDE_RIGHT);
        repeat (4) send_item(16'd200, SIDE_RIGHT);
        repeat (4) send_item(16'd200, SIDE_LEFT);
        repeat (4) send_item(16'd0, SIDE_LEFT);

        for (int round = 0; round < ROUNDS; round++) begin
            // sender pauses until every result is back before reconfiguring
            wait_idle();
            configure(round);
            case (round % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            run_random(ITEMS_PER_ROUND, (round % 4) == 0);
        end

        wait_idle();
        if (tracker.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
